### rtl/dense_layer_forward_defines.svh
// Assertion macros shared by the RTL files.
`ifndef DENSE_LAYER_FORWARD_DEFINES_SVH
`define DENSE_LAYER_FORWARD_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DLF_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define DLF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define DLF_ASSERT_NOW(label, pre, post, msg)
`define DLF_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

### rtl/dlf_pkg.sv
package dlf_pkg;

    // store dimensions
    localparam int IN_MAX  = 64;
    localparam int OUT_MAX = 32;

    // address widths into the stores
    localparam int CA_W = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int RA_W = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int WA_W = RA_W + CA_W;
    localparam int WDEPTH = OUT_MAX * (2 ** CA_W);

    // field widths
    localparam int OP_W     = 2;
    localparam int ROWIDX_W = 5;
    localparam int COLIDX_W = 6;
    localparam int SMP_W    = 16;
    localparam int BIAS_W   = 32;
    localparam int OUTV_W   = 32;
    localparam int VEC_W    = 8;

    // configuration register widths
    localparam int ILEN_W   = 7;
    localparam int OLEN_W   = 6;
    localparam int BLEN_W   = 9;
    localparam int CFGIDX_W = 2;
    localparam int CFGDAT_W = 9;
    localparam int BATCH_MAX = 256;

    // arithmetic
    localparam int PROD_W = 2 * SMP_W;
    localparam int ACC_W  = BIAS_W + CA_W + 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic [CFGIDX_W-1:0] REG_INPUT_LENGTH  = 2'd0;
    localparam logic [CFGIDX_W-1:0] REG_OUTPUT_LENGTH = 2'd1;
    localparam logic [CFGIDX_W-1:0] REG_BATCH_LENGTH  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic             w_we;      // store weight from input payload
        logic             b_we;      // store bias from input payload
        logic             x_we;      // store sample from input payload
        logic             issue;     // one MAC read this cycle
        logic             first;     // first column of a row
        logic             last;      // last column of a row
        logic [RA_W-1:0]  row;
        logic [CA_W-1:0]  col;
        logic [VEC_W-1:0] vec;
        logic             last_row;
        logic             last_batch;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;   // output register empty or emptying this cycle
        logic landed;     // row result enters output register this cycle
    } sts_t;

endpackage

### rtl/dlf_ram.sv
module dlf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/dlf_ctrl.sv
module dlf_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dlf_pkg::OP_W-1:0]     operation,
    input  logic [dlf_pkg::ROWIDX_W-1:0] row_index,
    input  logic [dlf_pkg::COLIDX_W-1:0] column_index,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dlf_pkg::CFGIDX_W-1:0] cfg_index,
    input  logic [dlf_pkg::CFGDAT_W-1:0] cfg_data,
    output dlf_pkg::cmd_t                cmd,
    input  dlf_pkg::sts_t                sts
);
    import dlf_pkg::*;
    `include "dense_layer_forward_defines.svh"

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WAIT  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [RA_W-1:0]   row_reg, row_next;
    logic [CA_W-1:0]   col_reg, col_next;
    logic [VEC_W-1:0]  vec_reg, vec_next;
    logic [ILEN_W-1:0] ilen_reg;
    logic [OLEN_W-1:0] olen_reg;
    logic [BLEN_W-1:0] blen_reg;

    logic [ILEN_W-1:0] ilen_eff;
    logic [OLEN_W-1:0] olen_eff;
    logic [BLEN_W-1:0] blen_eff;
    logic              in_acc;
    logic              col_ok;
    logic              row_ok;
    logic              trigger;
    logic              last_col;
    logic              last_row;
    logic              last_vec;

    // clamp lengths into legal range
    always_comb
    begin
        if (ilen_reg == '0)
            ilen_eff = ILEN_W'(1);
        else if (32'(ilen_reg) > IN_MAX)
            ilen_eff = ILEN_W'(IN_MAX);
        else
            ilen_eff = ilen_reg;

        if (olen_reg == '0)
            olen_eff = OLEN_W'(1);
        else if (32'(olen_reg) > OUT_MAX)
            olen_eff = OLEN_W'(OUT_MAX);
        else
            olen_eff = olen_reg;

        if (blen_reg == '0)
            blen_eff = BLEN_W'(1);
        else if (32'(blen_reg) > BATCH_MAX)
            blen_eff = BLEN_W'(BATCH_MAX);
        else
            blen_eff = blen_reg;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign col_ok   = (32'(column_index) < IN_MAX);
    assign row_ok   = (32'(row_index) < OUT_MAX);
    assign last_col = (ILEN_W'(col_reg) == ilen_eff - ILEN_W'(1));
    assign last_row = (OLEN_W'(row_reg) == olen_eff - OLEN_W'(1));
    assign last_vec = ({1'b0, vec_reg} + BLEN_W'(1) >= blen_eff);

    // item decode
    always_comb
    begin
        cmd.w_we = 1'b0;
        cmd.b_we = 1'b0;
        cmd.x_we = 1'b0;
        trigger  = 1'b0;
        unique case (operation)
            OP_WEIGHT:
            begin
                cmd.w_we = in_acc && row_ok && col_ok;
            end
            OP_BIAS:
            begin
                cmd.b_we = in_acc && row_ok;
            end
            OP_SAMPLE:
            begin
                cmd.x_we = in_acc && col_ok;
                trigger  = in_acc && col_ok &&
                           (ILEN_W'(column_index) == ilen_eff - ILEN_W'(1));
            end
            default:
            begin
                trigger = 1'b0;
            end
        endcase
    end

    assign cmd.issue      = (state_reg == S_ISSUE);
    assign cmd.first      = (col_reg == '0);
    assign cmd.last       = last_col;
    assign cmd.row        = row_reg;
    assign cmd.col        = col_reg;
    assign cmd.vec        = vec_reg;
    assign cmd.last_row   = last_row;
    assign cmd.last_batch = last_row && last_vec;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        vec_next   = vec_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (trigger)
                begin
                    row_next   = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (sts.out_free)
                begin
                    col_next   = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (last_col)
                    state_next = S_DRAIN;
                else
                    col_next = col_reg + CA_W'(1);
            end
            S_DRAIN:
            begin
                if (sts.landed)
                begin
                    if (last_row)
                    begin
                        vec_next   = last_vec ? '0 : vec_reg + VEC_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + RA_W'(1);
                        state_next = S_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            vec_reg   <= '0;
            ilen_reg  <= ILEN_W'(64);
            olen_reg  <= OLEN_W'(32);
            blen_reg  <= BLEN_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            vec_reg   <= vec_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_INPUT_LENGTH:  ilen_reg <= cfg_data[ILEN_W-1:0];
                    REG_OUTPUT_LENGTH: olen_reg <= cfg_data[OLEN_W-1:0];
                    REG_BATCH_LENGTH:  blen_reg <= cfg_data[BLEN_W-1:0];
                    default:           ilen_reg <= ilen_reg;
                endcase
            end
        end
    end

    `DLF_ASSERT_NOW(a_landed_in_drain, sts.landed, state_reg == S_DRAIN,
        "row result arrived outside drain")
    `DLF_ASSERT_NEXT(a_busy_after_trigger, trigger, !in_ready,
        "input accepted while a vector is computed")

endmodule

### rtl/dlf_datapath.sv
module dlf_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dlf_pkg::cmd_t                cmd,
    output dlf_pkg::sts_t                sts,
    input  logic [dlf_pkg::ROWIDX_W-1:0] row_index,
    input  logic [dlf_pkg::COLIDX_W-1:0] column_index,
    input  logic [dlf_pkg::SMP_W-1:0]    sample_or_weight,
    input  logic [dlf_pkg::BIAS_W-1:0]   bias_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dlf_pkg::OUTV_W-1:0]   output_value,
    output logic [dlf_pkg::ROWIDX_W-1:0] output_index,
    output logic [dlf_pkg::VEC_W-1:0]    vector_index,
    output logic                         last_of_vector,
    output logic                         last_of_batch
);
    import dlf_pkg::*;
    `include "dense_layer_forward_defines.svh"

    logic [SMP_W-1:0]  w_rd;
    logic [SMP_W-1:0]  x_rd;
    logic [BIAS_W-1:0] b_rd;

    // stage 1: memory read in flight
    logic v1_reg, first1_reg, last1_reg;
    // stage 2: product registered
    logic                     v2_reg, first2_reg, last2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [BIAS_W-1:0] bias2_reg;
    // stage 3: accumulator
    logic signed [ACC_W-1:0]  acc_reg, acc_next, acc_base;
    logic [OUTV_W-1:0]        sat_value;
    logic                     land;

    logic                out_valid_reg;
    logic [OUTV_W-1:0]   out_value_reg;
    logic [ROWIDX_W-1:0] out_index_reg;
    logic [VEC_W-1:0]    out_vec_reg;
    logic                out_lastv_reg;
    logic                out_lastb_reg;

    dlf_ram #(.WIDTH(SMP_W), .DEPTH(WDEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (cmd.w_we),
        .waddr ({row_index[RA_W-1:0], column_index[CA_W-1:0]}),
        .wdata (sample_or_weight),
        .raddr ({cmd.row, cmd.col}),
        .rdata (w_rd)
    );

    dlf_ram #(.WIDTH(BIAS_W), .DEPTH(OUT_MAX)) u_bias_ram (
        .clk   (clk),
        .we    (cmd.b_we),
        .waddr (row_index[RA_W-1:0]),
        .wdata (bias_value),
        .raddr (cmd.row),
        .rdata (b_rd)
    );

    dlf_ram #(.WIDTH(SMP_W), .DEPTH(IN_MAX)) u_input_ram (
        .clk   (clk),
        .we    (cmd.x_we),
        .waddr (column_index[CA_W-1:0]),
        .wdata (sample_or_weight),
        .raddr (cmd.col),
        .rdata (x_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        prod_reg   <= $signed(x_rd) * $signed(w_rd);
        bias2_reg  <= $signed(b_rd);
    end

    assign acc_base = first2_reg ? ACC_W'(bias2_reg) : acc_reg;
    assign acc_next = acc_base + ACC_W'(prod_reg);
    assign land     = v2_reg && last2_reg;

    // clamp to signed 32 bits
    always_comb
    begin
        if ((&acc_next[ACC_W-1:OUTV_W-1]) || !(|acc_next[ACC_W-1:OUTV_W-1]))
            sat_value = acc_next[OUTV_W-1:0];
        else if (acc_next[ACC_W-1])
            sat_value = {1'b1, {(OUTV_W-1){1'b0}}};
        else
            sat_value = {1'b0, {(OUTV_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (land)
        begin
            out_value_reg <= sat_value;
            out_index_reg <= ROWIDX_W'(cmd.row);
            out_vec_reg   <= cmd.vec;
            out_lastv_reg <= cmd.last_row;
            out_lastb_reg <= cmd.last_batch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (land)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.landed   = land;

    assign out_valid      = out_valid_reg;
    assign output_value   = out_value_reg;
    assign output_index   = out_index_reg;
    assign vector_index   = out_vec_reg;
    assign last_of_vector = out_lastv_reg;
    assign last_of_batch  = out_lastb_reg;

    `DLF_ASSERT_NOW(a_no_overwrite, land, !out_valid_reg,
        "row result would overwrite a pending output")
    `DLF_ASSERT_NOW(a_row_starts_empty, cmd.issue && cmd.first, !v1_reg && !v2_reg,
        "new row issued while MAC pipeline busy")

endmodule

### rtl/dense_layer_forward.sv
// Fully connected layer, forward pass. Each input transaction writes one
// Q4.12 weight, one Q8.24 bias or one Q4.12 input sample. The sample at
// column input_length-1 starts a vector: for every row the block runs one
// multiply-accumulate per cycle through a single MAC pipeline (weight, bias
// and input RAM reads, registered multiply, wide accumulate and saturate).
// The next row starts only once the output register is free, and in_ready
// stays low until the last row result is in the output register. Results
// come out in row order, saturated to 32-bit Q8.24, tagged with the row, the
// vector number in the batch and last flags. Stores power up undefined and
// need no clearing; entries must be written before they are used.
// Configuration writes are taken at any time and are meant to be issued
// only while the block is idle.
module dense_layer_forward (
    input  logic                         clk,
    input  logic                         rst_n,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dlf_pkg::OP_W-1:0]     operation,
    input  logic [dlf_pkg::ROWIDX_W-1:0] row_index,
    input  logic [dlf_pkg::COLIDX_W-1:0] column_index,
    input  logic [dlf_pkg::SMP_W-1:0]    sample_or_weight,
    input  logic [dlf_pkg::BIAS_W-1:0]   bias_value,
    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dlf_pkg::OUTV_W-1:0]   output_value,
    output logic [dlf_pkg::ROWIDX_W-1:0] output_index,
    output logic [dlf_pkg::VEC_W-1:0]    vector_index,
    output logic                         last_of_vector,
    output logic                         last_of_batch,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dlf_pkg::CFGIDX_W-1:0] cfg_index,
    input  logic [dlf_pkg::CFGDAT_W-1:0] cfg_data
);
    import dlf_pkg::*;

    cmd_t cmd;   // store writes, MAC issue and row tags
    sts_t sts;   // output register and pipeline status

    // sequencer: decodes transactions, holds config, walks rows and columns
    dlf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .row_index    (row_index),
        .column_index (column_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts)
    );

    // stores, MAC pipeline and output register
    dlf_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .row_index        (row_index),
        .column_index     (column_index),
        .sample_or_weight (sample_or_weight),
        .bias_value       (bias_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .output_value     (output_value),
        .output_index     (output_index),
        .vector_index     (vector_index),
        .last_of_vector   (last_of_vector),
        .last_of_batch    (last_of_batch)
    );

endmodule
